>>> src/sla_pkg.sv
// Shared types, constants and the truncation suffix table for the serial line assembler.
package sla_pkg;

	localparam int LineMax   = 64;
	localparam int SuffixLen = 12;
	localparam int PrefixMax = LineMax - SuffixLen;
	localparam int AddrW     = $clog2(LineMax);
	localparam int LenW      = $clog2(LineMax + 1);
	localparam int SufIdxW   = $clog2(SuffixLen);

	localparam logic [7:0]  CharCr        = 8'h0D;
	localparam logic [7:0]  CharLf        = 8'h0A;
	localparam logic [15:0] IdleTicksInit = 16'd5000;
	localparam logic [15:0] TickMax       = 16'hFFFF;

	typedef logic [AddrW-1:0]   addr_t;
	typedef logic [LenW-1:0]    len_t;
	typedef logic [SufIdxW-1:0] suf_idx_t;

	typedef enum logic [1:0] {
		ACT_BYTE = 2'd0,
		ACT_TICK = 2'd1,
		ACT_DROP = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_TRUNC = 2'd1,
		KIND_IDLE  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUFFIX,
		ST_READ,
		ST_SEND
	} state_t;

	// Characters of the " [truncated]" suffix.
	function automatic logic [7:0] suffix_char(input suf_idx_t idx);
		logic [7:0] c;
		c = 8'h20;
		case (idx)
			4'd0:    c = 8'h20;
			4'd1:    c = 8'h5B;
			4'd2:    c = 8'h74;
			4'd3:    c = 8'h72;
			4'd4:    c = 8'h75;
			4'd5:    c = 8'h6E;
			4'd6:    c = 8'h63;
			4'd7:    c = 8'h61;
			4'd8:    c = 8'h74;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h64;
			4'd11:   c = 8'h5D;
			default: c = 8'h20;
		endcase
		return c;
	endfunction

endpackage

>>> src/sla_if.sv
// Handshake channel interfaces for input beats and result beats.
interface sla_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] byte_value;

	modport source (output valid, output action, output byte_value, input ready);
	modport sink (input valid, input action, input byte_value, output ready);
endinterface

interface sla_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_out;
	logic       last;
	logic       stream_started;

	modport source (output valid, output kind, output char_out, output last,
		output stream_started, input ready);
	modport sink (input valid, input kind, input char_out, input last,
		input stream_started, output ready);
endinterface

>>> src/sla_line_mem.sv
// Line character store: one write port and one read port with registered read data.
module sla_line_mem (
	input  logic                clk,
	input  logic                we,
	input  sla_pkg::addr_t      waddr,
	input  logic [7:0]          wdata,
	input  logic                re,
	input  sla_pkg::addr_t      raddr,
	output logic [7:0]          rdata
);

	logic [7:0] mem [sla_pkg::LineMax];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/serial_line_assembler.sv
// Top level of the serial line assembler: control sequencer, registers and output stage.
//
// The block takes beats on byte_ch: action 0 carries a received byte, action 1 a time
// tick and action 2 discards the partial line. Result beats leave on result_ch: line
// characters (kind 0) with last and stream_started marks, a truncation notice (kind 1)
// and a stream idle notice (kind 2). cfg_we with cfg_wdata writes idle_ticks.
// Ordinary bytes, carriage returns, ticks and discards are handled in the idle state.
// A byte that overflows the line loads the truncation notice at once, then writes the
// twelve suffix characters into the line store. A line feed replays the stored line,
// up to 64 characters, one at a time: ST_READ reads a character from the line store
// (registered read data), then ST_SEND loads it into the output register, holding while
// the receiver stalls. The line store has a single read port, so these steps alternate.
// Reset returns every control register to its initial value, sets idle_ticks to 5000
// and marks the stream inactive; the line store needs no clearing because only written
// entries are ever read. When the receiver stalls, the output register holds its beat
// and the block stops accepting input until that beat is taken.
module serial_line_assembler (
	input  logic            clk,
	input  logic            arst_n,
	sla_in_if.sink          byte_ch,
	sla_out_if.source       result_ch,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata
);

	sla_pkg::state_t   state_q, state_d;
	sla_pkg::len_t     len_q, len_d;
	logic              trunc_q, trunc_d;
	logic              active_q, active_d;
	logic              started_q, started_d;
	logic [15:0]       ticks_q, ticks_d;
	logic [15:0]       idle_ticks_q;
	sla_pkg::addr_t    rd_idx_q, rd_idx_d;
	sla_pkg::suf_idx_t suf_idx_q, suf_idx_d;

	// Output stage.
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        char_q;
	logic              last_q;
	logic              started_out_q;

	logic              out_free;
	logic              in_ready;
	logic              accept;
	logic              out_load;
	sla_pkg::kind_t    out_kind;
	logic [7:0]        out_char;
	logic              out_last;
	logic              out_started;
	logic [15:0]       tick_next;

	// Line store port signals.
	logic              mem_we;
	sla_pkg::addr_t    mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [7:0]        mem_rdata;

	sla_line_mem u_line_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_idx_q),
		.rdata (mem_rdata)
	);

	assign out_free  = !out_valid_q || result_ch.ready;
	assign accept    = byte_ch.valid && in_ready;
	assign tick_next = (ticks_q == sla_pkg::TickMax) ? ticks_q : ticks_q + 16'd1;

	always_comb begin
		state_d     = state_q;
		len_d       = len_q;
		trunc_d     = trunc_q;
		active_d    = active_q;
		started_d   = started_q;
		ticks_d     = ticks_q;
		rd_idx_d    = rd_idx_q;
		suf_idx_d   = suf_idx_q;
		in_ready    = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = len_q[sla_pkg::AddrW-1:0];
		mem_wdata   = byte_ch.byte_value;
		mem_re      = 1'b0;
		out_load    = 1'b0;
		out_kind    = sla_pkg::KIND_CHAR;
		out_char    = 8'h00;
		out_last    = 1'b0;
		out_started = 1'b0;

		unique case (state_q)
			sla_pkg::ST_IDLE: begin
				in_ready = out_free;
				if (accept) begin
					case (byte_ch.action)
						sla_pkg::ACT_BYTE: begin
							if (byte_ch.byte_value == sla_pkg::CharCr) begin
								// Carriage returns are dropped.
							end else if (byte_ch.byte_value == sla_pkg::CharLf) begin
								trunc_d = 1'b0;
								if (len_q != '0) begin
									started_d = !active_q;
									active_d  = 1'b1;
									ticks_d   = '0;
									rd_idx_d  = '0;
									state_d   = sla_pkg::ST_READ;
								end
							end else if (!trunc_q) begin
								if (len_q < sla_pkg::LenW'(sla_pkg::PrefixMax)) begin
									mem_we = 1'b1;
									len_d  = len_q + sla_pkg::LenW'(1);
								end else begin
									// The line is full: append the suffix and report it.
									trunc_d   = 1'b1;
									len_d     = sla_pkg::LenW'(sla_pkg::LineMax);
									suf_idx_d = '0;
									state_d   = sla_pkg::ST_SUFFIX;
									out_load  = 1'b1;
									out_kind  = sla_pkg::KIND_TRUNC;
								end
							end
						end
						sla_pkg::ACT_TICK: begin
							ticks_d = tick_next;
							if (active_q && tick_next >= idle_ticks_q) begin
								active_d = 1'b0;
								out_load = 1'b1;
								out_kind = sla_pkg::KIND_IDLE;
							end
						end
						sla_pkg::ACT_DROP: begin
							len_d   = '0;
							trunc_d = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			sla_pkg::ST_SUFFIX: begin
				mem_we    = 1'b1;
				mem_waddr = sla_pkg::AddrW'(sla_pkg::PrefixMax)
					+ sla_pkg::AddrW'(suf_idx_q);
				mem_wdata = sla_pkg::suffix_char(suf_idx_q);
				if (suf_idx_q == sla_pkg::SufIdxW'(sla_pkg::SuffixLen - 1)) begin
					state_d = sla_pkg::ST_IDLE;
				end else begin
					suf_idx_d = suf_idx_q + sla_pkg::SufIdxW'(1);
				end
			end
			sla_pkg::ST_READ: begin
				mem_re  = 1'b1;
				state_d = sla_pkg::ST_SEND;
			end
			sla_pkg::ST_SEND: begin
				if (out_free) begin
					out_load    = 1'b1;
					out_kind    = sla_pkg::KIND_CHAR;
					out_char    = mem_rdata;
					out_last    = ({1'b0, rd_idx_q} + sla_pkg::LenW'(1)) == len_q;
					out_started = started_q && (rd_idx_q == '0);
					if (out_last) begin
						len_d   = '0;
						state_d = sla_pkg::ST_IDLE;
					end else begin
						rd_idx_d = rd_idx_q + sla_pkg::AddrW'(1);
						state_d  = sla_pkg::ST_READ;
					end
				end
			end
			default: begin
				state_d = sla_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sla_pkg::ST_IDLE;
			len_q        <= '0;
			trunc_q      <= 1'b0;
			active_q     <= 1'b0;
			started_q    <= 1'b0;
			ticks_q      <= '0;
			idle_ticks_q <= sla_pkg::IdleTicksInit;
			rd_idx_q     <= '0;
			suf_idx_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			len_q     <= len_d;
			trunc_q   <= trunc_d;
			active_q  <= active_d;
			started_q <= started_d;
			ticks_q   <= ticks_d;
			rd_idx_q  <= rd_idx_d;
			suf_idx_q <= suf_idx_d;
			if (cfg_we) begin
				idle_ticks_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload needs no reset; it is qualified by out_valid_q.
	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q        <= out_kind;
			char_q        <= out_char;
			last_q        <= out_last;
			started_out_q <= out_started;
		end
	end

	assign byte_ch.ready            = in_ready;
	assign result_ch.valid          = out_valid_q;
	assign result_ch.kind           = kind_q;
	assign result_ch.char_out       = char_q;
	assign result_ch.last           = last_q;
	assign result_ch.stream_started = started_out_q;

endmodule

>>> tb/tb_serial_line_assembler.sv
// Self-checking testbench for the serial line assembler: directed table, then random line traffic.
`timescale 1ns / 100ps

module tb_serial_line_assembler;
	import sla_pkg::*;

	// Timeout guard. The slowest correct run lets every input beat replay a full line
	// while the receiver stalls its longest, which stays well below this figure.
	localparam int LimitCycles = 2_000_000;
	// Cycles to let pass once nothing is expected any more. The block may still be
	// writing the twelve suffix characters after the truncation notice has gone out.
	localparam int SettleCycles = 24;
	localparam int DirRows = 35;
	localparam int PhaseItems = 24;

	// The action field is two bits wide, and its fourth code must do nothing at all.
	localparam logic [1:0] ActUnused = 2'd3;

	// The suffix appended to an overlong line, first character in the top byte.
	localparam logic [8*SuffixLen-1:0] TruncTail = " [truncated]";

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       last;
		logic       started;
	} beat_t;

	// How a row of the directed table is handled: checked by the predictor, typed in
	// as no beat at all, typed in as exactly one beat, or a write of idle_ticks.
	typedef enum logic [1:0] {
		ROW_MODEL,
		ROW_NONE,
		ROW_ONE,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t   rk;
		logic [1:0]  act;
		logic [7:0]  data;
		logic [7:0]  reps;
		logic [15:0] cfg_val;
		beat_t       want;
	} row_t;

	// Receiver behavior, changed every so many cycles.
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	localparam beat_t NoBeat    = '{KIND_CHAR, 8'h00, 1'b0, 1'b0};
	localparam beat_t TruncBeat = '{KIND_TRUNC, 8'h00, 1'b0, 1'b0};
	localparam beat_t IdleBeat  = '{KIND_IDLE, 8'h00, 1'b0, 1'b0};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	sla_in_if  byte_ch ();
	sla_out_if result_ch ();

	serial_line_assembler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Predictor state: its own copy of the partial line, the flags and the register.
	logic [7:0]  line_buf [LineMax];
	int unsigned pred_len;
	bit          trunc_seen;
	bit          stream_on;
	logic [15:0] ticks_idle;
	logic [15:0] idle_limit;

	// Result beats that the block owes, oldest first.
	beat_t pending_beats [$];

	int mismatch_count;
	int cycle_count;
	int burst_left;
	bit sender_steady;

	rx_mode_t   rx_mode;
	int         rx_left;
	logic [7:0] rx_pattern;

	row_t dir_rows [DirRows];

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// Works out what one accepted input beat does to the line state and queues the
	// result beats it causes. With queue_results low only the state moves, which is
	// how rows with a typed-in answer keep the predictor in step.
	task automatic assemble_step(input logic [1:0] act, input logic [7:0] data,
		input bit queue_results);
		beat_t       b;
		bit          first;
		int unsigned pos;
		case (act)
			ACT_BYTE: begin
				if (data == CharCr) begin
					// Carriage returns leave no trace.
				end else if (data == CharLf) begin
					if (pred_len != 0) begin
						first = !stream_on;
						stream_on = 1'b1;
						ticks_idle = '0;
						for (int i = 0; i < pred_len; i++) begin
							b.kind = KIND_CHAR;
							b.ch = line_buf[i];
							b.last = (i + 1 == pred_len);
							b.started = first && (i == 0);
							if (queue_results)
								pending_beats.push_back(b);
						end
					end
					// An empty line only clears the truncation state.
					pred_len = 0;
					trunc_seen = 1'b0;
				end else if (!trunc_seen) begin
					if (pred_len < PrefixMax) begin
						line_buf[pred_len] = data;
						pred_len++;
					end else begin
						// The overflowing byte itself is dropped and the suffix takes its place.
						for (int j = 0; j < SuffixLen; j++) begin
							pos = pred_len + j;
							if (pos < LineMax)
								line_buf[pos] = TruncTail[8*(SuffixLen-j)-1 -: 8];
						end
						pred_len = pred_len + SuffixLen;
						if (pred_len > LineMax)
							pred_len = LineMax;
						trunc_seen = 1'b1;
						if (queue_results)
							pending_beats.push_back(TruncBeat);
					end
				end
			end
			ACT_TICK: begin
				if (ticks_idle != TickMax)
					ticks_idle++;
				// The idle test comes after the count is raised.
				if (stream_on && ticks_idle >= idle_limit) begin
					stream_on = 1'b0;
					if (queue_results)
						pending_beats.push_back(IdleBeat);
				end
			end
			ACT_DROP: begin
				pred_len = 0;
				trunc_seen = 1'b0;
			end
			default: begin
			end
		endcase
	endtask

	// Offers one input beat and returns at the edge that takes it. The sender works in
	// bursts; between bursts valid drops for a few cycles unless the phase runs steady.
	// Valid is never lowered here right after a beat, so back-to-back beats keep it high.
	task automatic send_beat(input logic [1:0] act, input logic [7:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = sender_steady ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		byte_ch.valid <= 1'b1;
		byte_ch.action <= act;
		byte_ch.byte_value <= data;
		do
			@(posedge clk);
		while (!byte_ch.ready);
	endtask

	task automatic feed(input logic [1:0] act, input logic [7:0] data);
		send_beat(act, data);
		assemble_step(act, data, 1'b1);
	endtask

	// Stops the sender and waits until every owed beat has come out, then some more
	// cycles for work that produces nothing visible.
	task automatic drain();
		byte_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_idle_ticks(input logic [15:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		idle_limit = value;
	endtask

	// One phase of random traffic. Most of it is complete lines with random content,
	// some of them long enough to overflow; the rest is ticks, discards, lone line
	// feeds and the unused action. Carriage returns and the unused action do not count.
	task automatic random_phase(input int target);
		int counted;
		int pick;
		int len;
		counted = 0;
		while (counted < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(45, 70) : $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) == 0)
						feed(ACT_BYTE, CharCr);
					if ($urandom_range(0, 11) == 0) begin
						feed(ACT_TICK, 8'($urandom_range(0, 255)));
						counted++;
					end
					feed(ACT_BYTE, 8'($urandom_range(0, 255)));
					counted++;
				end
				if ($urandom_range(0, 3) == 0)
					feed(ACT_BYTE, CharCr);
				feed(ACT_BYTE, CharLf);
				counted++;
			end else if (pick < 80) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					feed(ACT_TICK, 8'($urandom_range(0, 255)));
					counted++;
				end
			end else if (pick < 88) begin
				// A broken line: a few characters, then the discard action.
				len = $urandom_range(0, 4);
				for (int i = 0; i < len; i++) begin
					feed(ACT_BYTE, 8'($urandom_range(0, 255)));
					counted++;
				end
				feed(ACT_DROP, 8'($urandom_range(0, 255)));
				counted++;
			end else if (pick < 94) begin
				feed(ActUnused, 8'($urandom_range(0, 255)));
			end else begin
				feed(ACT_BYTE, CharLf);
				counted++;
			end
		end
	endtask

	// Result side: checks every beat taken and plays the receiver's stall pattern.
	always @(posedge clk) begin : rx_side
		beat_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_beats.size() == 0) begin
					report_mismatch($sformatf("beat with nothing owed: kind %0d char %02h",
						result_ch.kind, result_ch.char_out));
				end else begin
					want = pending_beats.pop_front();
					if (result_ch.kind !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %0d",
							result_ch.kind, want.kind));
					if (result_ch.char_out !== want.ch)
						report_mismatch($sformatf("char_out %02h, expected %02h",
							result_ch.char_out, want.ch));
					if (result_ch.last !== want.last)
						report_mismatch($sformatf("last %b, expected %b",
							result_ch.last, want.last));
					if (result_ch.stream_started !== want.started)
						report_mismatch($sformatf("stream_started %b, expected %b",
							result_ch.stream_started, want.started));
				end
			end
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
				rx_pattern = 8'($urandom_range(1, 255));
			end
			rx_left--;
			case (rx_mode)
				RX_OPEN:    result_ch.ready <= 1'b1;
				RX_COIN:    result_ch.ready <= 1'($urandom_range(0, 1));
				RX_PATTERN: begin
					result_ch.ready <= rx_pattern[0];
					rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
				end
				default:    result_ch.ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LimitCycles) begin
			$display("serial_line_assembler test failed");
			$finish;
		end
	end

	initial begin
		row_t        row;
		logic [15:0] phase_limits [5];

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.action = ACT_BYTE;
		byte_ch.byte_value = 8'h00;
		result_ch.ready = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		burst_left = 0;
		sender_steady = 1'b0;
		rx_mode = RX_OPEN;
		rx_left = 0;
		rx_pattern = 8'hA5;

		// The predictor starts from the reset state of the block.
		pred_len = 0;
		trunc_seen = 1'b0;
		stream_on = 1'b0;
		ticks_idle = '0;
		idle_limit = IdleTicksInit;

		// Directed rows. Single beats and silent items are typed in; a replayed line
		// of several characters is left to the predictor.
		dir_rows = '{
			// Right after reset: nothing is active, so nothing comes out.
			'{ROW_NONE,  ACT_TICK,  8'h00, 8'd1,  16'd0, NoBeat},
			'{ROW_NONE,  ActUnused, 8'hFF, 8'd1,  16'd0, NoBeat},
			'{ROW_NONE,  ACT_BYTE,  CharLf, 8'd1, 16'd0, NoBeat},
			'{ROW_NONE,  ACT_BYTE,  CharCr, 8'd1, 16'd0, NoBeat},
			// A one-character line after reset starts the stream.
			'{ROW_NONE,  ACT_BYTE,  8'h00, 8'd1,  16'd0, NoBeat},
			'{ROW_ONE,   ACT_BYTE,  CharLf, 8'd1, 16'd0, '{KIND_CHAR, 8'h00, 1'b1, 1'b1}},
			'{ROW_NONE,  ACT_BYTE,  8'hFF, 8'd1,  16'd0, NoBeat},
			'{ROW_NONE,  ACT_BYTE,  CharCr, 8'd1, 16'd0, NoBeat},
			'{ROW_NONE,  ACT_BYTE,  8'h41, 8'd1,  16'd0, NoBeat},
			'{ROW_MODEL, ACT_BYTE,  CharLf, 8'd1, 16'd0, NoBeat},
			// A discarded partial line leaves an empty line behind.
			'{ROW_NONE,  ACT_BYTE,  8'h7E, 8'd1,  16'd0, NoBeat},
			'{ROW_NONE,  ACT_DROP,  8'h00, 8'd1,  16'd0, NoBeat},
			'{ROW_NONE,  ACT_BYTE,  CharLf, 8'd1, 16'd0, NoBeat},
			// Fill the line to its limit, overflow it, then replay the full 64 characters.
			'{ROW_NONE,  ACT_BYTE,  8'h55, 8'd52, 16'd0, NoBeat},
			'{ROW_ONE,   ACT_BYTE,  8'h62, 8'd1,  16'd0, TruncBeat},
			'{ROW_NONE,  ACT_BYTE,  8'h63, 8'd3,  16'd0, NoBeat},
			'{ROW_MODEL, ACT_BYTE,  CharLf, 8'd1, 16'd0, NoBeat},
			// A limit of one: the first tick after a line ends the stream.
			'{ROW_CFG,   ACT_BYTE,  8'h00, 8'd0,  16'd1, NoBeat},
			'{ROW_ONE,   ACT_TICK,  8'h00, 8'd1,  16'd0, IdleBeat},
			'{ROW_NONE,  ACT_TICK,  8'hFF, 8'd1,  16'd0, NoBeat},
			'{ROW_NONE,  ACT_BYTE,  8'h78, 8'd1,  16'd0, NoBeat},
			'{ROW_ONE,   ACT_BYTE,  CharLf, 8'd1, 16'd0, '{KIND_CHAR, 8'h78, 1'b1, 1'b1}},
			// A zero limit also goes idle on the next tick.
			'{ROW_CFG,   ACT_BYTE,  8'h00, 8'd0,  16'd0, NoBeat},
			'{ROW_ONE,   ACT_TICK,  8'h00, 8'd1,  16'd0, IdleBeat},
			'{ROW_NONE,  ACT_BYTE,  8'h79, 8'd1,  16'd0, NoBeat},
			'{ROW_NONE,  ACT_DROP,  8'hFF, 8'd1,  16'd0, NoBeat},
			'{ROW_NONE,  ACT_BYTE,  CharLf, 8'd1, 16'd0, NoBeat},
			// Discarding a truncated line clears the truncation as well.
			'{ROW_NONE,  ACT_BYTE,  8'h71, 8'd52, 16'd0, NoBeat},
			'{ROW_ONE,   ACT_BYTE,  8'h72, 8'd1,  16'd0, TruncBeat},
			'{ROW_NONE,  ACT_DROP,  8'h00, 8'd1,  16'd0, NoBeat},
			'{ROW_NONE,  ACT_BYTE,  CharLf, 8'd1, 16'd0, NoBeat},
			'{ROW_NONE,  ACT_BYTE,  8'h6B, 8'd1,  16'd0, NoBeat},
			'{ROW_ONE,   ACT_BYTE,  CharLf, 8'd1, 16'd0, '{KIND_CHAR, 8'h6B, 1'b1, 1'b1}},
			// Largest limit: a handful of ticks keeps the stream active.
			'{ROW_CFG,   ACT_BYTE,  8'h00, 8'd0,  16'hFFFF, NoBeat},
			'{ROW_MODEL, ACT_TICK,  8'h00, 8'd5,  16'd0, NoBeat}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DirRows; r++) begin
			row = dir_rows[r];
			if (row.rk == ROW_CFG) begin
				write_idle_ticks(row.cfg_val);
			end else begin
				for (int k = 0; k < row.reps; k++) begin
					send_beat(row.act, row.data);
					if (row.rk == ROW_ONE)
						pending_beats.push_back(row.want);
					assemble_step(row.act, row.data, row.rk == ROW_MODEL);
				end
			end
		end

		// Random phases, each under its own idle limit. Short limits make the idle
		// notices frequent; the largest limit lets lines run on, and the last limit is random.
		phase_limits[0] = 16'd3;
		phase_limits[1] = 16'hFFFF;
		phase_limits[2] = 16'd1;
		phase_limits[3] = 16'($urandom_range(2, 12));
		phase_limits[4] = 16'($urandom_range(1, 65535));
		for (int p = 0; p < 5; p++) begin
			write_idle_ticks(phase_limits[p]);
			sender_steady = ($urandom_range(0, 3) == 0);
			random_phase(PhaseItems);
		end

		drain();
		if (mismatch_count == 0)
			$display("serial_line_assembler test passed");
		else
			$display("serial_line_assembler test failed");
		$finish;
	end

endmodule
